[sv/field_pair_to_hsv_colormap_rgb_macros.svh]
// Assertion macros for the field pair to HSV colormap block.
`ifndef FIELD_PAIR_TO_HSV_COLORMAP_RGB_MACROS_SVH
`define FIELD_PAIR_TO_HSV_COLORMAP_RGB_MACROS_SVH
`ifndef SYNTHESIS
`define FP2HSV_ASSERT_IMP(label, ck, rs, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rs) (ante) |-> (cons)) \
        else $error("fp2hsv: implication check failed");
`define FP2HSV_ASSERT_NXT(label, ck, rs, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rs) (ante) |=> (cons)) \
        else $error("fp2hsv: next-cycle check failed");
`else
`define FP2HSV_ASSERT_IMP(label, ck, rs, ante, cons)
`define FP2HSV_ASSERT_NXT(label, ck, rs, ante, cons)
`endif
`endif

[sv/fp2hsv_pkg.sv]
// Shared types, register codes and helpers for the HSV colormap block.
`default_nettype none
package fp2hsv_pkg;

    localparam int IO_FRAC  = 16;
    localparam int SAMPLE_W = 18;
    localparam int CFG_W    = 18;
    localparam int INDEX_W  = 3;
    localparam int BYTE_W   = 8;
    localparam int UNIT_W   = 17;

    typedef enum logic [INDEX_W-1:0] {
        REG_SATURATION = 3'd0,
        REG_HUE_BASE   = 3'd1,
        REG_HUE_SPAN   = 3'd2,
        REG_CONTRAST   = 3'd3
    } reg_index_t;

    typedef enum logic [2:0] {
        SECT_R_TO_Y = 3'd0,
        SECT_Y_TO_G = 3'd1,
        SECT_G_TO_C = 3'd2,
        SECT_C_TO_B = 3'd3,
        SECT_B_TO_M = 3'd4,
        SECT_M_TO_R = 3'd5
    } hue_sector_t;

    // clamp a signed Q2.16 sample to [0, 1.0]
    function automatic logic [UNIT_W-1:0] clamp_unit(input logic signed [SAMPLE_W-1:0] s);
        logic [UNIT_W-1:0] r;
        if (s < 0)
            r = '0;
        else if (s > $signed(18'sd65536))
            r = 17'd65536;
        else
            r = s[UNIT_W-1:0];
        return r;
    endfunction

endpackage
`default_nettype wire

[sv/fp2hsv_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module fp2hsv_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 1025
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

[sv/field_pair_to_hsv_colormap_rgb.sv]
// Top level: field pair (u, v) to RGB bytes through an HSV colormap with gamma.
`default_nettype none
`include "field_pair_to_hsv_colormap_rgb_macros.svh"
// Accepts one pixel per clock while in_stall is low and returns its RGB bytes;
// the seven register stages (clamp, two products, hue/value sum, gamma table
// read, saturation products, channel products, byte scaling) each hold
// multipliers side by side or a short add and compare path. A stall on the output freezes every stage at
// once, so in_stall follows out_stall while a result is waiting. After reset
// the gamma table memory is loaded one entry per cycle, all 2^GAMMA_TABLE_BITS+1
// entries (1025 by default), while in_stall stays high; configuration writes
// are taken at any time and should be made only while no pixel is in flight.
module field_pair_to_hsv_colormap_rgb #(
    parameter int GAMMA_TABLE_BITS = 10,
    parameter int FRAC_BITS        = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic signed [fp2hsv_pkg::SAMPLE_W-1:0] u_sample,
    input  wire logic signed [fp2hsv_pkg::SAMPLE_W-1:0] v_sample,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [fp2hsv_pkg::BYTE_W-1:0]             red,
    output logic [fp2hsv_pkg::BYTE_W-1:0]             green,
    output logic [fp2hsv_pkg::BYTE_W-1:0]             blue,
    input  wire logic                                 cfg_write,
    input  wire logic [fp2hsv_pkg::INDEX_W-1:0]       cfg_index,
    input  wire logic [fp2hsv_pkg::CFG_W-1:0]         cfg_data
);

    localparam int F        = FRAC_BITS;
    localparam int G        = GAMMA_TABLE_BITS;
    localparam int VW       = F + 1;
    localparam int ROM_SIZE = (1 << G) + 1;
    localparam int AW       = $clog2(ROM_SIZE);
    localparam int SHL      = (F >= fp2hsv_pkg::IO_FRAC) ? F - fp2hsv_pkg::IO_FRAC : 0;
    localparam int SHR      = (F >= fp2hsv_pkg::IO_FRAC) ? 0 : fp2hsv_pkg::IO_FRAC - F;
    localparam int CONV_W   = 26;
    localparam int BIG      = 11 * VW + 5 * G + 2;

    localparam logic [VW-1:0] ONE  = VW'(1) << F;
    localparam logic [VW-1:0] HALF = VW'(1) << (F - 1);
    localparam logic [AW-1:0] LAST = AW'(ROM_SIZE - 1);

    typedef logic [VW-1:0] gamma_arr_t [ROM_SIZE];

    // entry k = floor(ONE * (k / 2^G)^(5/11)), by exact integer search
    function automatic gamma_arr_t build_gamma();
        gamma_arr_t tab;
        logic [BIG-1:0] rhs;
        logic [BIG-1:0] lhs;
        logic [VW:0]    lo;
        logic [VW:0]    hi;
        logic [VW:0]    mid;
        int k;
        int i;
        int it;
        for (k = 0; k < ROM_SIZE; k++)
        begin
            rhs = BIG'(1);
            for (i = 0; i < 5; i++)
                rhs = rhs * BIG'(k);
            rhs = rhs << (11 * F);
            lo = '0;
            hi = (VW + 1)'(ONE);
            for (it = 0; it < VW + 2; it++)
            begin
                if (lo < hi)
                begin
                    mid = lo + ((hi - lo + 1'b1) >> 1);
                    lhs = BIG'(1);
                    for (i = 0; i < 11; i++)
                        lhs = lhs * BIG'(mid);
                    lhs = lhs << (5 * G);
                    if (lhs <= rhs)
                        lo = mid;
                    else
                        hi = mid - 1'b1;
                end
            end
            tab[k] = lo[VW-1:0];
        end
        return tab;
    endfunction

    localparam gamma_arr_t GAMMA_TAB = build_gamma();

    function automatic logic [VW-1:0] mulr(input logic [VW-1:0] a, input logic [VW-1:0] b);
        logic [2*VW-1:0] pr;
        pr = (2*VW)'(a) * (2*VW)'(b) + (2*VW)'(HALF);
        return pr[F+VW-1:F];
    endfunction

    function automatic logic [fp2hsv_pkg::BYTE_W-1:0] to_byte(input logic [VW-1:0] x);
        logic [F+8:0] m;
        logic [8:0]   b;
        m = ((F+9)'(x) << 8) - (F+9)'(x) + (F+9)'(HALF);
        b = m[F+8:F];
        return (b > 9'd255) ? 8'd255 : b[7:0];
    endfunction

    // configuration
    logic [16:0] sat_reg;
    logic [15:0] base_reg;
    logic [16:0] span_reg;
    logic [17:0] gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_reg  <= 17'd58982;
            base_reg <= 16'd36045;
            span_reg <= 17'd22938;
            gain_reg <= 18'd72090;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                fp2hsv_pkg::REG_SATURATION: sat_reg  <= cfg_data[16:0];
                fp2hsv_pkg::REG_HUE_BASE:   base_reg <= cfg_data[15:0];
                fp2hsv_pkg::REG_HUE_SPAN:   span_reg <= cfg_data[16:0];
                fp2hsv_pkg::REG_CONTRAST:   gain_reg <= cfg_data[17:0];
                default: ;
            endcase
        end
    end

    logic [16:0]   sat_cl;
    logic [F-1:0]  base_fx;
    logic [VW-1:0] span_fx;
    logic [F+1:0]  gain_fx;
    logic [VW-1:0] sat_fx;

    assign sat_cl  = (sat_reg > 17'd65536) ? 17'd65536 : sat_reg;
    assign base_fx = F'((CONV_W'(base_reg) << SHL) >> SHR);
    assign span_fx = VW'((CONV_W'(span_reg) << SHL) >> SHR);
    assign gain_fx = (F+2)'((CONV_W'(gain_reg) << SHL) >> SHR);
    assign sat_fx  = VW'((CONV_W'(sat_cl) << SHL) >> SHR);

    // gamma table load after reset
    logic          fill_reg;
    logic          fill_next;
    logic [AW-1:0] fill_cnt_reg;
    logic [AW-1:0] fill_cnt_next;

    always_comb
    begin
        fill_next     = fill_reg;
        fill_cnt_next = fill_cnt_reg;
        if (fill_reg)
        begin
            if (fill_cnt_reg == LAST)
                fill_next = 1'b0;
            else
                fill_cnt_next = fill_cnt_reg + 1'b1;
        end
    end

    // pipeline control
    logic       advance;
    logic       accept;
    logic [5:0] vld_reg;
    logic [5:0] vld_next;
    logic       out_valid_reg;

    assign advance  = !(out_valid_reg && out_stall);
    assign in_stall = fill_reg || !advance;
    assign accept   = in_valid && !in_stall;
    assign vld_next = {vld_reg[4:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= 1'b1;
            fill_cnt_reg  <= '0;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg     <= fill_next;
            fill_cnt_reg <= fill_cnt_next;
            if (advance)
            begin
                vld_reg       <= vld_next;
                out_valid_reg <= vld_reg[5];
            end
        end
    end

    // stage 1: clamped samples
    logic [VW-1:0] s1_u_reg, s1_v_reg;
    logic [VW-1:0] s1_u_next, s1_v_next;

    assign s1_u_next = VW'((CONV_W'(fp2hsv_pkg::clamp_unit(u_sample)) << SHL) >> SHR);
    assign s1_v_next = VW'((CONV_W'(fp2hsv_pkg::clamp_unit(v_sample)) << SHL) >> SHR);

    // stage 2: hue and value products
    logic signed [F+1:0]   du_s, dv_s;
    logic signed [2*F+3:0] s2_hue_prod_reg, s2_hue_prod_next;
    logic signed [2*F+4:0] s2_val_prod_reg, s2_val_prod_next;

    assign du_s = $signed({1'b0, s1_u_reg}) - $signed({2'b00, HALF[F-1:0]});
    assign dv_s = $signed({1'b0, s1_v_reg}) - $signed({2'b00, HALF[F-1:0]});
    assign s2_hue_prod_next = du_s * $signed({1'b0, span_fx});
    assign s2_val_prod_next = $signed({1'b0, gain_fx}) * dv_s;

    // stage 3: wrapped hue, value and table address
    logic [2*F-1:0]        hue_sum;
    logic signed [2*F+5:0] num;
    logic signed [2*F+5:0] num_rnd;
    logic [F+5:0]          val_rnd;
    logic [VW-1:0]         val;
    logic [F+G:0]          idx_wide;
    logic [F-1:0]          s3_hue_reg, s3_hue_next;
    logic [AW-1:0]         s3_idx_reg, s3_idx_next;

    always_comb
    begin
        hue_sum = {base_fx, {F{1'b0}}} + s2_hue_prod_reg[2*F-1:0] + (2*F)'(HALF);
        s3_hue_next = hue_sum[2*F-1:F];
        num = $signed({6'b000000, 1'b1, {(2*F-1){1'b0}}}) + (2*F+6)'(s2_val_prod_reg);
        // rounded sum taken beside num, not after it
        num_rnd = $signed({6'b000000, 1'b1, {(2*F-1){1'b0}}}) + (2*F+6)'(s2_val_prod_reg)
                  + $signed((2*F+6)'(HALF));
        val_rnd = num_rnd[2*F+5:F];
        if (num <= 0)
            val = '0;
        else if (val_rnd > (F+6)'(ONE))
            val = ONE;
        else
            val = val_rnd[VW-1:0];
        idx_wide = ({val, {G{1'b0}}} + (F+G+1)'(HALF)) >> F;
        if (idx_wide > (F+G+1)'(LAST))
            s3_idx_next = LAST;
        else
            s3_idx_next = idx_wide[AW-1:0];
    end

    // stage 4: gamma value from table, sector and fraction
    logic [VW-1:0]           vg;
    logic [F+2:0]            hh;
    fp2hsv_pkg::hue_sector_t s4_sect_reg, s4_sect_next;
    logic [F-1:0]            s4_f_reg, s4_f_next;

    fp2hsv_ram #(
        .WIDTH (VW),
        .DEPTH (ROM_SIZE)
    ) u_gamma_ram (
        .clk     (clk),
        .wr_en   (fill_reg),
        .wr_addr (fill_cnt_reg),
        .wr_data (GAMMA_TAB[fill_cnt_reg]),
        .rd_en   (advance),
        .rd_addr (s3_idx_reg),
        .rd_data (vg)
    );

    assign hh           = ((F+3)'(s3_hue_reg) << 2) + ((F+3)'(s3_hue_reg) << 1);
    assign s4_sect_next = fp2hsv_pkg::hue_sector_t'(hh[F+2:F]);
    assign s4_f_next    = hh[F-1:0];

    // stage 5: saturation products and p
    logic [VW-1:0]           s5_msf_reg, s5_msnf_reg, s5_p_reg, s5_vg_reg;
    fp2hsv_pkg::hue_sector_t s5_sect_reg;

    // stage 6: q and t
    logic [VW-1:0]           s6_q_reg, s6_t_reg, s6_p_reg, s6_vg_reg;
    fp2hsv_pkg::hue_sector_t s6_sect_reg;

    // output: channel select and byte scaling
    logic [VW-1:0] rf, gf, bf;
    logic [fp2hsv_pkg::BYTE_W-1:0] red_reg, green_reg, blue_reg;

    always_comb
    begin
        case (s6_sect_reg)
            fp2hsv_pkg::SECT_R_TO_Y:
            begin
                rf = s6_vg_reg;
                gf = s6_t_reg;
                bf = s6_p_reg;
            end
            fp2hsv_pkg::SECT_Y_TO_G:
            begin
                rf = s6_q_reg;
                gf = s6_vg_reg;
                bf = s6_p_reg;
            end
            fp2hsv_pkg::SECT_G_TO_C:
            begin
                rf = s6_p_reg;
                gf = s6_vg_reg;
                bf = s6_t_reg;
            end
            fp2hsv_pkg::SECT_C_TO_B:
            begin
                rf = s6_p_reg;
                gf = s6_q_reg;
                bf = s6_vg_reg;
            end
            fp2hsv_pkg::SECT_B_TO_M:
            begin
                rf = s6_t_reg;
                gf = s6_p_reg;
                bf = s6_vg_reg;
            end
            default:
            begin
                rf = s6_vg_reg;
                gf = s6_p_reg;
                bf = s6_q_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_u_reg        <= s1_u_next;
            s1_v_reg        <= s1_v_next;
            s2_hue_prod_reg <= s2_hue_prod_next;
            s2_val_prod_reg <= s2_val_prod_next;
            s3_hue_reg      <= s3_hue_next;
            s3_idx_reg      <= s3_idx_next;
            s4_sect_reg     <= s4_sect_next;
            s4_f_reg        <= s4_f_next;
            s5_msf_reg      <= mulr(sat_fx, {1'b0, s4_f_reg});
            s5_msnf_reg     <= mulr(sat_fx, ONE - {1'b0, s4_f_reg});
            s5_p_reg        <= mulr(vg, ONE - sat_fx);
            s5_vg_reg       <= vg;
            s5_sect_reg     <= s4_sect_reg;
            s6_q_reg        <= mulr(s5_vg_reg, ONE - s5_msf_reg);
            s6_t_reg        <= mulr(s5_vg_reg, ONE - s5_msnf_reg);
            s6_p_reg        <= s5_p_reg;
            s6_vg_reg       <= s5_vg_reg;
            s6_sect_reg     <= s5_sect_reg;
            red_reg         <= to_byte(rf);
            green_reg       <= to_byte(gf);
            blue_reg        <= to_byte(bf);
        end
    end

    assign out_valid = out_valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

    `FP2HSV_ASSERT_IMP(a_no_request_while_loading, clk, rst_n, fill_reg, in_stall)
    `FP2HSV_ASSERT_NXT(a_request_enters_pipe, clk, rst_n, accept, vld_reg[0])
    `FP2HSV_ASSERT_NXT(a_last_stage_reaches_out, clk, rst_n, vld_reg[5] && advance, out_valid)

endmodule
`default_nettype wire

[verif/tb_field_pair_to_hsv_colormap_rgb.sv]
// Self-checking testbench for the field pair to HSV colormap RGB block.
`timescale 1ns / 100ps

module tb_field_pair_to_hsv_colormap_rgb;
    import fp2hsv_pkg::*;

    localparam int          FRAC            = 16;
    localparam int          GAMMA_BITS      = 10;
    localparam int          GAMMA_TOP       = 1 << GAMMA_BITS;
    localparam logic [63:0] ONE             = 64'd65536;
    localparam logic [63:0] HALF            = 64'd32768;
    localparam int unsigned CYCLE_LIMIT     = 1000000;
    localparam int          HOLD_OFF_CYCLES = 300;
    localparam int          DRAIN_PAD       = 20;
    localparam int          PHASES          = 7;
    localparam int          PHASE_REQUESTS  = 250;
    localparam int          REPORT_CAP      = 50;

    localparam logic [INDEX_W-1:0] REG_SPARE_FIRST = 3'd4;
    localparam logic [INDEX_W-1:0] REG_SPARE_LAST  = 3'd7;

    localparam logic [16:0] SAT_RESET      = 17'd58982;
    localparam logic [15:0] BASE_RESET     = 16'd36045;
    localparam logic [16:0] SPAN_RESET     = 17'd22938;
    localparam logic [17:0] CONTRAST_RESET = 18'd72090;

    localparam logic [SAMPLE_W-1:0] S_MIN  = 18'h20000;
    localparam logic [SAMPLE_W-1:0] S_MAX  = 18'h1FFFF;
    localparam logic [SAMPLE_W-1:0] S_ZERO = 18'h00000;
    localparam logic [SAMPLE_W-1:0] S_ONE  = 18'h10000;
    localparam logic [SAMPLE_W-1:0] S_HALF = 18'h08000;
    localparam logic [SAMPLE_W-1:0] S_NEG1 = 18'h3FFFF;
    localparam logic [SAMPLE_W-1:0] S_OVER = 18'h10001;
    localparam logic [BYTE_W-1:0]   B_MAX  = 8'd255;
    localparam logic [BYTE_W-1:0]   B_MIN  = 8'd0;

    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
    } pixel_rgb_t;

    typedef enum bit {ROW_PIXEL, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t           kind;
        logic [INDEX_W-1:0]  index;
        logic [CFG_W-1:0]    data;
        logic [SAMPLE_W-1:0] u;
        logic [SAMPLE_W-1:0] v;
        bit                  typed;
        pixel_rgb_t          rgb;
    } stim_row_t;

    localparam pixel_rgb_t RGB_NONE  = '{B_MIN, B_MIN, B_MIN};
    localparam pixel_rgb_t RGB_WHITE = '{B_MAX, B_MAX, B_MAX};
    localparam pixel_rgb_t RGB_RED   = '{B_MAX, B_MIN, B_MIN};
    localparam pixel_rgb_t RGB_GREEN = '{B_MIN, B_MAX, B_MIN};
    localparam pixel_rgb_t RGB_BLUE  = '{B_MIN, B_MIN, B_MAX};

    // rows without a typed colour are checked against the predictor
    stim_row_t directed_rows [35] = '{
        '{ROW_PIXEL, REG_SATURATION, 18'd0,      S_MIN,   S_MIN,   1'b1, RGB_NONE},
        '{ROW_PIXEL, REG_SATURATION, 18'd0,      S_MAX,   S_ZERO,  1'b1, RGB_NONE},
        '{ROW_PIXEL, REG_SATURATION, 18'd0,      S_ZERO,  S_MAX,   1'b0, RGB_NONE},
        '{ROW_PIXEL, REG_SATURATION, 18'd0,      S_HALF,  S_HALF,  1'b0, RGB_NONE},
        '{ROW_PIXEL, REG_SATURATION, 18'd0,      S_ONE,   S_ONE,   1'b0, RGB_NONE},
        '{ROW_PIXEL, REG_SATURATION, 18'd0,      S_NEG1,  S_OVER,  1'b0, RGB_NONE},
        '{ROW_WRITE, REG_SATURATION, 18'd0,      S_ZERO,  S_ZERO,  1'b0, RGB_NONE},
        '{ROW_PIXEL, REG_SATURATION, 18'd0,      S_HALF,  S_MAX,   1'b1, RGB_WHITE},
        '{ROW_PIXEL, REG_SATURATION, 18'd0,      S_MIN,   S_ONE,   1'b1, RGB_WHITE},
        '{ROW_WRITE, REG_SATURATION, 18'h3FFFF,  S_ZERO,  S_ZERO,  1'b0, RGB_NONE},
        '{ROW_WRITE, REG_HUE_SPAN,   18'd0,      S_ZERO,  S_ZERO,  1'b0, RGB_NONE},
        '{ROW_WRITE, REG_HUE_BASE,   18'd0,      S_ZERO,  S_ZERO,  1'b0, RGB_NONE},
        '{ROW_PIXEL, REG_SATURATION, 18'd0,      S_HALF,  S_MAX,   1'b1, RGB_RED},
        '{ROW_WRITE, REG_HUE_BASE,   18'd21846,  S_ZERO,  S_ZERO,  1'b0, RGB_NONE},
        '{ROW_PIXEL, REG_SATURATION, 18'd0,      S_HALF,  S_ONE,   1'b1, RGB_GREEN},
        '{ROW_WRITE, REG_HUE_BASE,   18'd43691,  S_ZERO,  S_ZERO,  1'b0, RGB_NONE},
        '{ROW_PIXEL, REG_SATURATION, 18'd0,      S_ZERO,  S_MAX,   1'b1, RGB_BLUE},
        '{ROW_WRITE, REG_HUE_BASE,   18'h3FFFF,  S_ZERO,  S_ZERO,  1'b0, RGB_NONE},
        '{ROW_PIXEL, REG_SATURATION, 18'd0,      S_HALF,  S_MAX,   1'b0, RGB_NONE},
        '{ROW_WRITE, REG_SPARE_FIRST, 18'd0,     S_ZERO,  S_ZERO,  1'b0, RGB_NONE},
        '{ROW_WRITE, REG_SPARE_LAST, 18'h3FFFF,  S_ZERO,  S_ZERO,  1'b0, RGB_NONE},
        '{ROW_PIXEL, REG_SATURATION, 18'd0,      S_HALF,  S_ONE,   1'b0, RGB_NONE},
        '{ROW_WRITE, REG_HUE_SPAN,   18'h10000,  S_ZERO,  S_ZERO,  1'b0, RGB_NONE},
        '{ROW_PIXEL, REG_SATURATION, 18'd0,      S_ZERO,  S_MAX,   1'b0, RGB_NONE},
        '{ROW_PIXEL, REG_SATURATION, 18'd0,      S_MAX,   S_MAX,   1'b0, RGB_NONE},
        '{ROW_WRITE, REG_HUE_SPAN,   18'h3FFFF,  S_ZERO,  S_ZERO,  1'b0, RGB_NONE},
        '{ROW_PIXEL, REG_SATURATION, 18'd0,      S_ONE,   S_ONE,   1'b0, RGB_NONE},
        '{ROW_PIXEL, REG_SATURATION, 18'd0,      18'h0C000, S_ONE, 1'b0, RGB_NONE},
        '{ROW_WRITE, REG_CONTRAST,   18'h3FFFF,  S_ZERO,  S_ZERO,  1'b0, RGB_NONE},
        '{ROW_PIXEL, REG_SATURATION, 18'd0,      S_HALF,  S_HALF,  1'b0, RGB_NONE},
        '{ROW_PIXEL, REG_SATURATION, 18'd0,      S_HALF,  18'h08001, 1'b0, RGB_NONE},
        '{ROW_PIXEL, REG_SATURATION, 18'd0,      S_HALF,  18'h07FFF, 1'b0, RGB_NONE},
        '{ROW_WRITE, REG_CONTRAST,   18'd0,      S_ZERO,  S_ZERO,  1'b0, RGB_NONE},
        '{ROW_PIXEL, REG_SATURATION, 18'd0,      S_MIN,   S_MIN,   1'b0, RGB_NONE},
        '{ROW_PIXEL, REG_SATURATION, 18'd0,      S_MAX,   S_MAX,   1'b0, RGB_NONE}
    };

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] u_sample  = '0;
    logic signed [SAMPLE_W-1:0] v_sample  = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [BYTE_W-1:0]          red;
    logic [BYTE_W-1:0]          green;
    logic [BYTE_W-1:0]          blue;
    logic                       cfg_write = 1'b0;
    logic [INDEX_W-1:0]         cfg_index = '0;
    logic [CFG_W-1:0]           cfg_data  = '0;

    logic [16:0] sat_q  = SAT_RESET;
    logic [15:0] base_q = BASE_RESET;
    logic [16:0] span_q = SPAN_RESET;
    logic [17:0] gain_q = CONTRAST_RESET;
    logic [16:0] gamma_lut [GAMMA_TOP+1];

    pixel_rgb_t  rgb_expected [$];
    int          error_count  = 0;
    int unsigned cycle_count  = 0;
    bit          idle_on      = 1'b1;
    bit          hold_off_req = 1'b0;
    bit          holding      = 1'b0;

    field_pair_to_hsv_colormap_rgb u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .u_sample  (u_sample),
        .v_sample  (v_sample),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // exact floor(2^16 * (k/2^10)^(5/11)): largest y with y^11 <= k^5 * 2^126
    function automatic logic [16:0] gamma_root(input int unsigned k);
        logic [191:0] rhs;
        logic [191:0] lhs;
        int unsigned  lo;
        int unsigned  hi;
        int unsigned  mid;
        rhs = 192'(k);
        repeat (4) rhs = rhs * k;
        rhs = rhs << 126;
        lo = 0;
        hi = 65536;
        while (lo < hi)
        begin
            mid = lo + (hi - lo + 1) / 2;
            lhs = 192'(mid);
            repeat (10) lhs = lhs * mid;
            if (lhs <= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo[16:0];
    endfunction

    initial
    begin
        for (int k = 0; k <= GAMMA_TOP; k++)
            gamma_lut[k] = gamma_root(k);
    end

    function automatic logic [63:0] unit_of(input logic signed [SAMPLE_W-1:0] s);
        if (s < 0)
            return 64'd0;
        if (s > 18'sd65536)
            return ONE;
        return 64'(s);
    endfunction

    function automatic logic [63:0] mul_q16(input logic [63:0] a, input logic [63:0] b);
        return (a * b + HALF) >> FRAC;
    endfunction

    function automatic logic [BYTE_W-1:0] to_channel(input logic [63:0] x);
        logic [63:0] s;
        s = (x * 255 + HALF) >> FRAC;
        return (s > 255) ? B_MAX : s[BYTE_W-1:0];
    endfunction

    function automatic pixel_rgb_t hsv_colormap(input logic signed [SAMPLE_W-1:0] u_in,
                                                input logic signed [SAMPLE_W-1:0] v_in);
        logic [63:0] u, v, sat, hue, val, idx, vg, hh, f, p, q, t, rf, gf, bf;
        longint      num;
        pixel_rgb_t  px;
        u   = unit_of(u_in);
        v   = unit_of(v_in);
        sat = (sat_q > 17'd65536) ? ONE : 64'(sat_q);
        hue = (64'(base_q) << FRAC) + u * 64'(span_q) - HALF * 64'(span_q) + HALF;
        hue = (hue >> FRAC) & (ONE - 1);
        num = longint'(HALF * ONE) + longint'(64'(gain_q) * v) - longint'(64'(gain_q) * HALF);
        if (num <= 0)
            val = 64'd0;
        else
        begin
            val = (64'(num) + HALF) >> FRAC;
            if (val > ONE)
                val = ONE;
        end
        idx = ((val << GAMMA_BITS) + HALF) >> FRAC;
        if (idx > GAMMA_TOP)
            idx = GAMMA_TOP;
        vg = 64'(gamma_lut[idx[10:0]]);
        hh = hue * 6;
        f  = hh & (ONE - 1);
        p  = mul_q16(vg, ONE - sat);
        q  = mul_q16(vg, ONE - mul_q16(sat, f));
        t  = mul_q16(vg, ONE - mul_q16(sat, ONE - f));
        case (hue_sector_t'(hh[18:16]))
            SECT_R_TO_Y: begin rf = vg; gf = t;  bf = p;  end
            SECT_Y_TO_G: begin rf = q;  gf = vg; bf = p;  end
            SECT_G_TO_C: begin rf = p;  gf = vg; bf = t;  end
            SECT_C_TO_B: begin rf = p;  gf = q;  bf = vg; end
            SECT_B_TO_M: begin rf = t;  gf = p;  bf = vg; end
            default:     begin rf = vg; gf = p;  bf = q;  end
        endcase
        px.red   = to_channel(rf);
        px.green = to_channel(gf);
        px.blue  = to_channel(bf);
        return px;
    endfunction

    task automatic log_mismatch(input string what, input int got, input int want);
        if (error_count < REPORT_CAP)
            $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
        error_count++;
    endtask

    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (!idle_on || hold_off_req || holding || pick < 70)
            return 0;
        if (pick < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 65)
            return SAMPLE_W'($urandom_range(0, 65536));
        if (pick < 80)
        begin
            case ($urandom_range(0, 6))
                0:       return S_MIN;
                1:       return S_MAX;
                2:       return S_ZERO;
                3:       return S_ONE;
                4:       return S_NEG1;
                5:       return S_OVER;
                default: return S_HALF;
            endcase
        end
        return SAMPLE_W'($urandom);
    endfunction

    task automatic offer_pixel(input logic signed [SAMPLE_W-1:0] u, input logic signed [SAMPLE_W-1:0] v,
                               input bit typed, input pixel_rgb_t want);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        u_sample <= u;
        v_sample <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        rgb_expected.push_back(typed ? want : hsv_colormap(u, v));
    endtask

    task automatic drain_pipeline();
        @(negedge clk);
        in_valid <= 1'b0;
        while (rgb_expected.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [INDEX_W-1:0] index, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        case (index)
            REG_SATURATION: sat_q  = data[16:0];
            REG_HUE_BASE:   base_q = data[15:0];
            REG_HUE_SPAN:   span_q = data[16:0];
            REG_CONTRAST:   gain_q = data;
            default:        ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    always @(posedge clk)
    begin : rgb_monitor
        pixel_rgb_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (rgb_expected.size() == 0)
                log_mismatch("unrequested pixel", {red, green, blue}, -1);
            else
            begin
                want = rgb_expected.pop_front();
                if (red !== want.red)
                    log_mismatch("red", red, want.red);
                if (green !== want.green)
                    log_mismatch("green", green, want.green);
                if (blue !== want.blue)
                    log_mismatch("blue", blue, want.blue);
            end
        end
    end

    // output back-pressure; a long hold fills the pipe and stalls the input
    initial
    begin : receiver
        int run;
        int pick;
        run = 0;
        forever
        begin
            @(negedge clk);
            if (run <= 0)
            begin
                pick = $urandom_range(0, 99);
                if (hold_off_req)
                begin
                    hold_off_req = 1'b0;
                    holding      = 1'b1;
                    out_stall   <= 1'b1;
                    run          = HOLD_OFF_CYCLES;
                end
                else
                begin
                    holding = 1'b0;
                    if (!idle_on || pick < 60)
                    begin
                        out_stall <= 1'b0;
                        run = $urandom_range(1, 8);
                    end
                    else if (pick < 95)
                    begin
                        out_stall <= 1'b1;
                        run = $urandom_range(1, 3);
                    end
                    else
                    begin
                        out_stall <= 1'b1;
                        run = $urandom_range(20, 60);
                    end
                end
            end
            run = run - 1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [CFG_W-1:0] sat_set, base_set, span_set, gain_set;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_WRITE)
            begin
                drain_pipeline();
                write_register(directed_rows[i].index, directed_rows[i].data);
            end
            else
                offer_pixel(directed_rows[i].u, directed_rows[i].v,
                            directed_rows[i].typed, directed_rows[i].rgb);
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain_pipeline();
            case (phase)
                0:
                begin
                    sat_set  = CFG_W'(SAT_RESET);
                    base_set = CFG_W'(BASE_RESET);
                    span_set = CFG_W'(SPAN_RESET);
                    gain_set = CONTRAST_RESET;
                end
                1:
                begin
                    sat_set  = 18'd65536;
                    base_set = 18'd65535;
                    span_set = 18'd65536;
                    gain_set = 18'd262143;
                end
                2:
                begin
                    sat_set  = '0;
                    base_set = '0;
                    span_set = '0;
                    gain_set = '0;
                end
                default:
                begin
                    sat_set  = ($urandom_range(0, 9) == 0) ? CFG_W'($urandom_range(65537, 131071))
                                                           : CFG_W'($urandom_range(0, 65536));
                    base_set = CFG_W'($urandom_range(0, 65535));
                    span_set = ($urandom_range(0, 9) == 0) ? CFG_W'($urandom_range(65537, 131071))
                                                           : CFG_W'($urandom_range(0, 65536));
                    gain_set = CFG_W'($urandom_range(0, 262143));
                end
            endcase
            write_register(REG_CONTRAST, gain_set);
            write_register(REG_HUE_SPAN, span_set);
            write_register(REG_HUE_BASE, base_set);
            write_register(REG_SATURATION, sat_set);
            if (phase >= 3)
                write_register(INDEX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                               CFG_W'($urandom));
            idle_on = (phase != 2);

            for (int n = 0; n < PHASE_REQUESTS; n++)
            begin
                if (phase == 3 && n == 100)
                    hold_off_req = 1'b1;
                if (phase == 4 && n == 125)
                    drain_pipeline();
                offer_pixel(rand_sample(), rand_sample(), 1'b0, RGB_NONE);
            end
        end

        drain_pipeline();
        repeat (DRAIN_PAD) @(posedge clk);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
